// ===== rtl/cmce_pkg.sv =====
// cmce_pkg: types, constants and helpers shared by the per-class mean and
// covariance estimator. No dependencies.
`timescale 1ns / 1ps
package cmce_pkg;

  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned CntW       = 17;
  localparam int unsigned SumW       = 33;
  localparam int unsigned SqW        = 48;
  localparam int unsigned DivW       = 64;
  localparam logic [16:0] ThreshReset = 17'd58982;
  localparam logic [31:0] OutlierVar  = 32'd327680;
  localparam logic [1:0]  OutlierIdx  = 2'd3;

  typedef struct packed {
    logic signed [15:0] intensity_x;
    logic signed [15:0] intensity_y;
    logic               point_missing;
    logic [16:0]        prob_class_zero;
    logic [16:0]        prob_class_one;
    logic [16:0]        prob_class_two;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic [1:0]         cluster_index;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [31:0] var_xx;
    logic signed [31:0] var_xy;
    logic signed [31:0] var_yy;
    logic [16:0]        weight;
    logic               too_few_points;
    logic               last_cluster;
  } record_t;

  // controller to datapath
  typedef struct packed {
    logic       accum;
    logic       clear;
    logic [1:0] cls;
    logic [3:0] op;
    logic       div_start;
    logic       emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // emission micro-ops
  typedef enum logic [3:0] {
    OpMeanX  = 4'd0,
    OpMeanY  = 4'd1,
    OpWeight = 4'd2,
    OpQa     = 4'd3,
    OpQb     = 4'd4,
    OpCovA   = 4'd5,
    OpCovB   = 4'd6,
    OpNone   = 4'd7
  } op_e;

endpackage

// ===== rtl/cmce_div.sv =====
// cmce_div: signed-by-positive floor divider, one quotient bit per cycle.
// Depends on cmce_pkg.
`timescale 1ns / 1ps
module cmce_div import cmce_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DivW-1:0] num_i,
  input  logic        [DivW-2:0] den_i,
  output logic                   done_o,
  output logic signed [DivW-1:0] quo_o,
  output logic signed [DivW-1:0] rem_o
);
  logic [DivW-1:0] mag_q, mag_d, rem_q, rem_d;
  logic [DivW-2:0] den_q, den_d;
  logic            neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [DivW:0]   trial;
  logic [DivW-1:0] shifted;

  always_comb begin
    mag_d = mag_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    shifted = {rem_q[DivW-2:0], mag_q[DivW-1]};
    trial = {1'b0, shifted} - {2'b0, den_q};
    if (start_i) begin
      neg_d  = num_i[DivW-1];
      mag_d  = num_i[DivW-1] ? DivW'(-num_i) : DivW'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      busy_d = 1'b1;
      cnt_d  = 7'(DivW);
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        mag_d = {mag_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        mag_d = {mag_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  // floor correction for negative numerators
  always_comb begin
    if (neg_q && rem_q != '0) begin
      quo_o = -$signed(mag_q) - 64'sd1;
      rem_o = $signed({1'b0, den_q}) - $signed(rem_q);
    end else begin
      quo_o = neg_q ? -$signed(mag_q) : $signed(mag_q);
      rem_o = $signed(rem_q);
    end
  end
  assign done_o = done_q;
endmodule

// ===== rtl/cmce_dp.sv =====
// cmce_dp: accumulators, final-statistics arithmetic and the result register.
// Depends on cmce_pkg and cmce_div.
`timescale 1ns / 1ps
module cmce_dp import cmce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sample_t     sample_i,
  input  logic [16:0] thresh_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic        valid_o,
  output record_t     rec_o
);
  logic [CntW-1:0]        cnt_q   [4];
  logic signed [SumW-1:0] sx_q    [4];
  logic signed [SumW-1:0] sy_q    [4];
  logic signed [SqW-1:0]  sxx_q   [3];
  logic signed [SqW-1:0]  sxy_q   [3];
  logic signed [SqW-1:0]  syy_q   [3];
  logic [CntW-1:0]        total_q;

  logic [1:0]             g;
  logic                   take;
  logic signed [31:0]     pxx, pxy, pyy;

  always_comb begin
    if (sample_i.prob_class_zero >= thresh_i)     g = 2'd0;
    else if (sample_i.prob_class_one >= thresh_i) g = 2'd1;
    else if (sample_i.prob_class_two >= thresh_i) g = 2'd2;
    else                                          g = OutlierIdx;
    take = cmd_i.accum && !sample_i.point_missing && (total_q < CntW'(MaxSamples));
    pxx = sample_i.intensity_x * sample_i.intensity_x;
    pxy = sample_i.intensity_x * sample_i.intensity_y;
    pyy = sample_i.intensity_y * sample_i.intensity_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0; sx_q[i] <= '0; sy_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        sxx_q[i] <= '0; sxy_q[i] <= '0; syy_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      total_q <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0; sx_q[i] <= '0; sy_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        sxx_q[i] <= '0; sxy_q[i] <= '0; syy_q[i] <= '0;
      end
    end else if (take) begin
      total_q  <= total_q + 1'b1;
      cnt_q[g] <= cnt_q[g] + 1'b1;
      sx_q[g]  <= sx_q[g] + SumW'(sample_i.intensity_x);
      sy_q[g]  <= sy_q[g] + SumW'(sample_i.intensity_y);
      if (g != OutlierIdx) begin
        sxx_q[g] <= sxx_q[g] + SqW'(pxx);
        sxy_q[g] <= sxy_q[g] + SqW'(pxy);
        syy_q[g] <= syy_q[g] + SqW'(pyy);
      end
    end
  end

  // ---- emission arithmetic, one division at a time ----
  logic signed [DivW-1:0] n, sa, sb, sp, num;
  logic [DivW-2:0]        den;
  logic                   dv_done;
  logic signed [DivW-1:0] dq, dr;
  logic [1:0]             c;
  logic signed [DivW-1:0] qa_q, ra_q, qb_q, rb_q, ca_q, d_w, e_w;
  logic [1:0]             pair_q;
  logic signed [15:0]     mx_q, my_q;
  logic signed [31:0]     vxx_q, vxy_q, vyy_q;
  logic [16:0]            w_q;
  logic signed [DivW-1:0] ee_q;
  logic signed [DivW-1:0] r_w;
  // narrow products: means fit 16 bits, remainders and counts 17 bits
  logic [CntW-1:0]        nm1;
  logic signed [48:0]     qs_p;
  logic signed [35:0]     rq_p, rn_p, rr_p;
  logic [33:0]            nn_p;

  assign c  = cmd_i.cls;
  assign n  = DivW'(cnt_q[c]);

  // pair_q: 0 xx, 1 xy, 2 yy (advanced after each OpCovB division, cleared on emit)
  always_comb begin
    sa = (pair_q == 2'd2) ? DivW'(sy_q[c]) : DivW'(sx_q[c]);
    sb = (pair_q == 2'd0) ? DivW'(sx_q[c]) : DivW'(sy_q[c]);
    case (pair_q)
      2'd0:    sp = (c == OutlierIdx) ? '0 : DivW'(sxx_q[c[1] ? 2'd2 : c]);
      2'd1:    sp = (c == OutlierIdx) ? '0 : DivW'(sxy_q[c[1] ? 2'd2 : c]);
      default: sp = (c == OutlierIdx) ? '0 : DivW'(syy_q[c[1] ? 2'd2 : c]);
    endcase
    nm1  = CntW'(cnt_q[c] - 1'b1);
    qs_p = $signed(qa_q[15:0]) * $signed(sb[32:0]);
    rq_p = $signed(ra_q[17:0]) * $signed(qb_q[15:0]);
    rn_p = $signed(dr[17:0]) * $signed(n[17:0]);
    rr_p = $signed(ra_q[17:0]) * $signed(rb_q[17:0]);
    nn_p = cnt_q[c] * nm1;
    d_w = sp - DivW'(qs_p) - DivW'(rq_p);
    e_w = DivW'(rn_p) - DivW'(rr_p);
    num = '0;
    den = (DivW-1)'(1);
    case (cmd_i.op)
      OpMeanX:  begin num = 2 * DivW'(sx_q[c]) + n; den = (DivW-1)'(2 * n); end
      OpMeanY:  begin num = 2 * DivW'(sy_q[c]) + n; den = (DivW-1)'(2 * n); end
      OpWeight: begin
        num = 2 * n * 65536 + DivW'(total_q);
        den = (DivW-1)'(2 * DivW'(total_q));
      end
      OpQa:     begin num = sa; den = (DivW-1)'(n); end
      OpQb:     begin num = sb; den = (DivW-1)'(n); end
      OpCovA:   begin num = d_w; den = (DivW-1)'(nm1); end
      OpCovB:   begin num = 2 * ee_q + DivW'(nn_p); den = (DivW-1)'({nn_p, 1'b0}); end
      default:  begin num = '0; den = (DivW-1)'(1); end
    endcase
  end

  cmce_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num), .den_i(den),
    .done_o(dv_done), .quo_o(dq), .rem_o(dr)
  );
  assign stat_o.div_done = dv_done;

  function automatic logic signed [31:0] sat32(logic signed [DivW-1:0] v);
    if (v > 64'sd2147483647)       return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction
  function automatic logic signed [15:0] sat16(logic signed [DivW-1:0] v);
    if (v > 64'sd32767)       return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  assign r_w = ca_q + dq;
  logic few;
  assign few = (c == OutlierIdx) ? (cnt_q[c] == '0) : (cnt_q[c] < CntW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else if (cmd_i.emit) begin
      pair_q <= '0;
    end else if (dv_done && cmd_i.op == OpCovB) begin
      pair_q <= (pair_q == 2'd2) ? 2'd0 : pair_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mx_q <= '0; my_q <= '0; vxx_q <= '0; vxy_q <= '0; vyy_q <= '0; w_q <= '0;
    end else if (dv_done) begin
      case (cmd_i.op)
        OpMeanX:  mx_q <= sat16(dq);
        OpMeanY:  my_q <= sat16(dq);
        OpWeight: w_q  <= dq[16:0];
        OpQa:     begin qa_q <= dq; ra_q <= dr; end
        OpQb:     begin qb_q <= dq; rb_q <= dr; end
        OpCovA:   begin ca_q <= dq; ee_q <= e_w; end
        OpCovB: begin
          case (pair_q)
            2'd0:    vxx_q <= sat32(r_w);
            2'd1:    vxy_q <= sat32(r_w);
            default: vyy_q <= sat32(r_w);
          endcase
        end
        default: ;
      endcase
    end
  end

  // result register
  logic    valid_q;
  record_t rec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= cmd_i.emit;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rec_q.cluster_index  <= c;
      rec_q.mean_x         <= few ? '0 : mx_q;
      rec_q.mean_y         <= few ? '0 : my_q;
      rec_q.var_xx         <= (c == OutlierIdx) ? OutlierVar : (few ? '0 : vxx_q);
      rec_q.var_xy         <= (c == OutlierIdx || few) ? '0 : vxy_q;
      rec_q.var_yy         <= (c == OutlierIdx) ? OutlierVar : (few ? '0 : vyy_q);
      rec_q.weight         <= (total_q == '0) ? '0 : w_q;
      rec_q.too_few_points <= few;
      rec_q.last_cluster   <= (c == OutlierIdx);
    end
  end
  assign valid_o = valid_q;
  assign rec_o   = rec_q;
endmodule

// ===== rtl/cmce_ctrl.sv =====
// cmce_ctrl: sequencer that accepts samples and walks the four classes
// through the divider at the end of a set. Depends on cmce_pkg.
`timescale 1ns / 1ps
module cmce_ctrl import cmce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     last_i,
  input  dp_stat_t stat_i,
  output logic     busy_o,
  output dp_cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StIss  = 4'b0010,
    StWait = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e     st_q, st_d;
  logic [1:0] cls_q, cls_d;
  op_e        op_q, op_d;
  logic [1:0] pair_q, pair_d;
  op_e        nxt;

  // op after the current one; covariance pairs loop three times
  always_comb begin
    nxt = OpNone;
    case (op_q)
      OpMeanX:  nxt = OpMeanY;
      OpMeanY:  nxt = OpWeight;
      OpWeight: nxt = (cls_q == OutlierIdx) ? OpNone : OpQa;
      OpQa:     nxt = OpQb;
      OpQb:     nxt = OpCovA;
      OpCovA:   nxt = OpCovB;
      OpCovB:   nxt = (pair_q == 2'd2) ? OpNone : OpQa;
      default:  nxt = OpNone;
    endcase
  end

  always_comb begin
    st_d = st_q; cls_d = cls_q; op_d = op_q; pair_d = pair_q;
    cmd_o = '0;
    cmd_o.cls = cls_q;
    cmd_o.op  = op_q;
    unique case (st_q)
      StIdle: begin
        cmd_o.accum = start_i;
        if (start_i && last_i) begin
          st_d = StIss; cls_d = '0; op_d = OpMeanX; pair_d = '0;
        end
      end
      StIss: begin
        cmd_o.div_start = 1'b1;
        st_d = StWait;
      end
      StWait: begin
        if (stat_i.div_done) begin
          if (op_q == OpCovB) pair_d = pair_q + 2'd1;
          op_d = nxt;
          st_d = (nxt == OpNone) ? StEmit : StIss;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        pair_d = '0;
        op_d = OpMeanX;
        if (cls_q == OutlierIdx) begin
          cmd_o.clear = 1'b1;
          st_d = StIdle;
        end else begin
          cls_d = cls_q + 2'd1;
          st_d = StIss;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cls_q <= '0; op_q <= OpMeanX; pair_q <= '0;
    end else begin
      st_q <= st_d; cls_q <= cls_d; op_q <= op_d; pair_q <= pair_d;
    end
  end
  assign busy_o = (st_q != StIdle);
endmodule

// ===== rtl/cluster_mean_covariance_estimator.sv =====
// Top level of the per-class mean and covariance estimator.
// Depends on cmce_pkg, cmce_ctrl and cmce_dp.
`timescale 1ns / 1ps
// A sample is taken while start_i is high and busy_o is low. A sample marked
// last_sample raises busy_o and starts the report: for each class the
// shared 64-step radix-2 divider runs its means, weight and covariance
// terms, 15 divisions for each of classes 0..2 and three for the outlier
// class, then the class record is emitted. One record per class leaves on
// result_o with result_valid_o high for one cycle. The receiver cannot
// stall; records come in class order 0..3.
module cluster_mean_covariance_estimator import cmce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  sample_t     sample_i,
  output logic        result_valid_o,
  output record_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [16:0] thresh_q;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                                         thresh_q <= ThreshReset;
    else if (psel && penable && pwrite && paddr == 1'b0) thresh_q <= pwdata[16:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {15'd0, thresh_q} : 32'd0;

  cmce_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .last_i(sample_i.last_sample),
    .stat_i(stat), .busy_o, .cmd_o(cmd)
  );
  cmce_dp u_dp (
    .clk_i, .rst_ni, .sample_i, .thresh_i(thresh_q), .cmd_i(cmd),
    .stat_o(stat), .valid_o(result_valid_o), .rec_o(result_o)
  );
endmodule

// ===== tb/tb_cluster_mean_covariance_estimator.sv =====
// Self-checking testbench for cluster_mean_covariance_estimator: directed table, then random
// sample sets, checked record by record against a per-class accumulator model.
// Depends on cmce_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_cluster_mean_covariance_estimator;
  import cmce_pkg::*;

  localparam int unsigned CycleLimit = 10000000;
  localparam int unsigned SettleCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  sample_t     sample_i = '0;
  logic        result_valid_o;
  record_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cluster_mean_covariance_estimator dut (.*);

  always #2 clk_i = ~clk_i;

  // model state
  logic [16:0] thresh_q;
  longint      cnt_q [4];
  longint      sx_q [4];
  longint      sy_q [4];
  longint      sxx_q [3];
  longint      sxy_q [3];
  longint      syy_q [3];
  record_t     pending_records [$];

  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned sender_idle_pct;

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if (a % d < 0) q -= 1;
    return q;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // exact (sp - sa*sb/n)/(n-1), rounded half up once
  function automatic longint cov_term(longint sp, longint sa, longint sb, longint n);
    longint qa, ra, qb, rb, d, a, b, e, den;
    qa = floor_div(sa, n);
    ra = sa - qa * n;
    qb = floor_div(sb, n);
    rb = sb - qb * n;
    d = sp - qa * sb - ra * qb;
    a = floor_div(d, n - 1);
    b = d - a * (n - 1);
    e = b * n - ra * rb;
    den = n * (n - 1);
    return sat(a + floor_div(2 * e + den, 2 * den), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void clear_sums();
    for (int k = 0; k < 4; k++) begin
      cnt_q[k] = 0;
      sx_q[k] = 0;
      sy_q[k] = 0;
      if (k < 3) begin
        sxx_q[k] = 0;
        sxy_q[k] = 0;
        syy_q[k] = 0;
      end
    end
  endfunction

  // accumulate one request; on last_sample queue the four class records
  function automatic void accumulate_sample(sample_t s);
    longint x, y, total, n;
    int g;
    record_t r;
    bit few;
    x = longint'($signed(s.intensity_x));
    y = longint'($signed(s.intensity_y));
    total = cnt_q[0] + cnt_q[1] + cnt_q[2] + cnt_q[3];
    if (!s.point_missing && total < MaxSamples) begin
      g = 3;
      if (s.prob_class_zero >= thresh_q) g = 0;
      else if (s.prob_class_one >= thresh_q) g = 1;
      else if (s.prob_class_two >= thresh_q) g = 2;
      cnt_q[g] += 1;
      sx_q[g] += x;
      sy_q[g] += y;
      if (g < 3) begin
        sxx_q[g] += x * x;
        sxy_q[g] += x * y;
        syy_q[g] += y * y;
      end
      total += 1;
    end
    if (!s.last_sample) return;
    for (int k = 0; k < 4; k++) begin
      n = cnt_q[k];
      few = (k < 3) ? (n < 2) : (n < 1);
      r = '0;
      r.cluster_index = 2'(k);
      if (!few) begin
        r.mean_x = 16'(sat(floor_div(2 * sx_q[k] + n, 2 * n), -32768, 32767));
        r.mean_y = 16'(sat(floor_div(2 * sy_q[k] + n, 2 * n), -32768, 32767));
        if (k < 3) begin
          r.var_xx = 32'(cov_term(sxx_q[k], sx_q[k], sx_q[k], n));
          r.var_xy = 32'(cov_term(sxy_q[k], sx_q[k], sy_q[k], n));
          r.var_yy = 32'(cov_term(syy_q[k], sy_q[k], sy_q[k], n));
        end
      end
      if (k == 3) begin
        r.var_xx = OutlierVar;
        r.var_yy = OutlierVar;
      end
      if (total > 0) r.weight = 17'(floor_div(2 * n * 65536 + total, 2 * total));
      r.too_few_points = few;
      r.last_cluster = (k == 3);
      pending_records.push_back(r);
    end
    clear_sums();
  endfunction

  // report with nothing accumulated, as read straight off the spec
  function automatic void queue_empty_report();
    record_t r;
    for (int k = 0; k < 4; k++) begin
      r = '0;
      r.cluster_index = 2'(k);
      r.var_xx = (k == 3) ? OutlierVar : '0;
      r.var_yy = (k == 3) ? OutlierVar : '0;
      r.too_few_points = 1'b1;
      r.last_cluster = (k == 3);
      pending_records.push_back(r);
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("cluster_mean_covariance_estimator: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    record_t want;
    if (result_valid_o) begin
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %p", result_o);
      end else begin
        want = pending_records.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch: idx %0d/%0d mean %0d,%0d/%0d,%0d var %0d,%0d,%0d/%0d,%0d,%0d w %0d/%0d few %b/%b last %b/%b",
                     want.cluster_index, result_o.cluster_index,
                     want.mean_x, want.mean_y, result_o.mean_x, result_o.mean_y,
                     want.var_xx, want.var_xy, want.var_yy,
                     result_o.var_xx, result_o.var_xy, result_o.var_yy,
                     want.weight, result_o.weight, want.too_few_points,
                     result_o.too_few_points, want.last_cluster, result_o.last_cluster);
        end
      end
    end
  end

  task automatic send_sample(sample_t s);
    int unsigned gap;
    gap = 0;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    sample_i <= s;
    // busy_o only moves on rising edges, so the negedge value holds at the next edge
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    accumulate_sample(s);
  endtask

  task automatic go_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [16:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= 32'(v);
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thresh_q = v;
  endtask

  function automatic sample_t mk(logic [15:0] x, logic [15:0] y, bit miss,
                                 logic [16:0] p0, logic [16:0] p1, logic [16:0] p2,
                                 bit last);
    sample_t s;
    s.intensity_x = x;
    s.intensity_y = y;
    s.point_missing = miss;
    s.prob_class_zero = p0;
    s.prob_class_one = p1;
    s.prob_class_two = p2;
    s.last_sample = last;
    return s;
  endfunction

  // mostly clean calls near one class, some noisy probabilities and points
  function automatic sample_t random_sample(bit last);
    sample_t s;
    int cls;
    s = '0;
    cls = $urandom_range(3);
    if ($urandom_range(3) == 0) begin
      s.intensity_x = 16'($urandom);
      s.intensity_y = 16'($urandom);
    end else begin
      s.intensity_x = 16'(cls * 300 - 400 + $urandom_range(255));
      s.intensity_y = 16'(700 - cls * 350 + $urandom_range(255));
    end
    if ($urandom_range(4) == 0) begin
      s.prob_class_zero = 17'($urandom);
      s.prob_class_one = 17'($urandom);
      s.prob_class_two = 17'($urandom);
    end else begin
      s.prob_class_zero = (cls == 0) ? 17'($urandom_range(65536, 58000)) : 17'($urandom_range(6000));
      s.prob_class_one = (cls == 1) ? 17'($urandom_range(65536, 58000)) : 17'($urandom_range(6000));
      s.prob_class_two = (cls == 2) ? 17'($urandom_range(65536, 58000)) : 17'($urandom_range(6000));
    end
    s.point_missing = ($urandom_range(9) == 0);
    s.last_sample = last;
    return s;
  endfunction

  typedef struct {
    sample_t smp;
    bit      empty_report;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{mk(16'h1234, 16'h5678, 1, 17'd65536, 0, 0, 1), 1},
    '{mk(16'h7FFF, 16'h8000, 0, 17'd65536, 0, 0, 0), 0},
    '{mk(16'h8000, 16'h7FFF, 0, 17'd65536, 0, 0, 1), 0},
    '{mk(16'h8000, 16'h8000, 0, 0, 0, 0, 0), 0},
    '{mk(16'h0100, 16'hFF00, 0, 17'd65536, 0, 0, 1), 0},
    '{mk(16'h0080, 16'h0040, 0, 0, 17'd58982, 0, 0), 0},
    '{mk(16'h0200, 16'h0300, 0, 0, 17'd58981, 17'd65536, 0), 0},
    '{mk(16'h0201, 16'h02FF, 0, 0, 0, 17'd58982, 0), 0},
    '{mk(16'h7FFF, 16'h7FFF, 0, 0, 0, 17'd65536, 0), 0},
    '{mk(16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 1), 0},
    '{mk(16'h0001, 16'h0001, 0, 17'h1FFFF, 0, 0, 0), 0},
    '{mk(16'h0002, 16'hFFFE, 0, 17'd58981, 17'h1FFFF, 0, 0), 0},
    '{mk(16'h00FF, 16'hFF01, 0, 17'h10000, 17'h1FFFF, 17'h1FFFF, 0), 0},
    '{mk(16'h5555, 16'hAAAA, 0, 17'h0AAAA, 17'h15555, 0, 0), 0},
    '{mk(16'hAAAA, 16'h5555, 0, 0, 0, 17'h15555, 0), 0},
    '{mk(16'h8001, 16'h7FFE, 0, 0, 0, 0, 1), 0}
  };

  logic [16:0] phase_thresh [4] = '{17'd0, 17'h1FFFF, 17'd65536, 17'd32768};
  int unsigned phase_idle [4] = '{0, 86, 0, 16};

  initial begin
    int unsigned set_len;
    thresh_q = ThreshReset;
    clear_sums();
    mismatches = 0;
    cycle_cnt = 0;
    sender_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].smp);
      if (directed_rows[i].empty_report) begin
        // replace the model's report with the literal one
        repeat (4) void'(pending_records.pop_back());
        queue_empty_report();
      end
    end
    go_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(phase_thresh[ph]);
      sender_idle_pct = phase_idle[ph];
      for (int i = 0; i < 90; i += set_len) begin
        set_len = ($urandom_range(7) == 0) ? 1 : $urandom_range(16, 2);
        for (int j = 0; j < set_len; j++) send_sample(random_sample(j == set_len - 1));
      end
      go_idle();
    end

    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("cluster_mean_covariance_estimator: match");
    end else begin
      $display("cluster_mean_covariance_estimator: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cmce_pkg.sv
rtl/cmce_div.sv
rtl/cmce_dp.sv
rtl/cmce_ctrl.sv
rtl/cluster_mean_covariance_estimator.sv
tb/tb_cluster_mean_covariance_estimator.sv
